FILE: design/srpe_pkg.sv
// Shared types and fixed field widths for the slot record and playback engine.
package srpe_pkg;

   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 4;
   localparam int VALUE_W  = 8;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;

   typedef enum logic [ACTION_W-1:0] {
      ACT_START_RECORD  = 3'd0,
      ACT_RECORD_SAMPLE = 3'd1,
      ACT_STOP_RECORD   = 3'd2,
      ACT_START_PLAY    = 3'd3,
      ACT_STOP_PLAY     = 3'd4,
      ACT_PLAY_TICK     = 3'd5,
      ACT_ERASE         = 3'd6,
      ACT_QUERY         = 3'd7
   } action_type;

endpackage

FILE: design/slot_record_playback_engine_unit.sv
// Slot record and playback engine: command decode, slot bookkeeping and sample store.
//
//   channel   ports                                    handshake
//   -------   --------------------------------------   ------------------------------
//   request   start, busy, req_* (four fields)         taken when start and not busy
//   response  rsp_valid, rsp_* (five fields)           rsp_valid strobe, one cycle
//   config    csr_wr_en, csr_wr_data (period in ms)    written on csr_wr_en
//
// One word is taken every clock; busy stays low. The response for a word passes first
// through the input register and then through the response register, which drives the outputs.
// The sample store read for the next play tick is issued at the edge that retires the
// current word, so a back-to-back play tick sees its value with a single store port.
// Reset is synchronous and needs no clearing pass: a per-slot high-water mark makes store
// entries that were never written read as zero. The receiver cannot stall responses.
module slot_record_playback_engine_unit
   import srpe_pkg::*;
#(
   parameter int NUM_SLOTS     = 10,
   parameter int SLOT_CAPACITY = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [VALUE_W-1:0]  req_slider_value,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic                csr_wr_en,
   input  logic [PERIOD_W-1:0] csr_wr_data,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_play_value,
   output logic                rsp_playing,
   output logic [SLOT_W-1:0]   rsp_playing_slot,
   output logic                rsp_slot_recorded,
   output logic                rsp_recording
);

   localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int POS_W  = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
   localparam int LEN_W  = $clog2(SLOT_CAPACITY + 1);
   localparam int DEPTH  = NUM_SLOTS * SLOT_CAPACITY;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [SLOT_W:0]     NUM_SLOTS_V = (SLOT_W + 1)'(NUM_SLOTS);
   localparam logic [LEN_W-1:0]    CAP_LEN     = LEN_W'(SLOT_CAPACITY);
   localparam logic [ADDR_W-1:0]   CAP_ADDR    = ADDR_W'(SLOT_CAPACITY);

   function automatic logic elapsed(input logic [TIME_W-1:0]   now,
                                    input logic [TIME_W-1:0]   last,
                                    input logic [PERIOD_W-1:0] period);
      logic [TIME_W-1:0] diff;
      diff = now - last;
      return diff >= TIME_W'(period);
   endfunction

   // Input register
   logic                in_vld_ff;
   action_type          act_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [TIME_W-1:0]   now_ff;

   logic [PERIOD_W-1:0] period_ff;

   // Per-slot bookkeeping, read only at the requested slot.
   logic [LEN_W-1:0]    len_ff  [NUM_SLOTS];
   logic [LEN_W-1:0]    len_in  [NUM_SLOTS];
   logic [LEN_W-1:0]    hw_ff   [NUM_SLOTS];
   logic [LEN_W-1:0]    hw_in   [NUM_SLOTS];
   logic                done_ff [NUM_SLOTS];
   logic                done_in [NUM_SLOTS];

   // Record and playback state, with local copies of the length and high-water mark
   // of the recording slot and of the playback slot.
   logic                rec_act_ff, rec_act_in;
   logic [IDX_W-1:0]    rec_slot_ff, rec_slot_in;
   logic [TIME_W-1:0]   rec_last_ff, rec_last_in;
   logic [LEN_W-1:0]    rec_len_ff, rec_len_in;
   logic [LEN_W-1:0]    rec_hw_ff, rec_hw_in;
   logic                play_act_ff, play_act_in;
   logic [IDX_W-1:0]    play_slot_ff, play_slot_in;
   logic [POS_W-1:0]    play_pos_ff, play_pos_in;
   logic [TIME_W-1:0]   play_last_ff, play_last_in;
   logic [LEN_W-1:0]    play_len_ff, play_len_in;
   logic [LEN_W-1:0]    play_hw_ff, play_hw_in;

   // Sample store and its read path
   logic [VALUE_W-1:0]  sample_mem [DEPTH];
   logic [VALUE_W-1:0]  mem_q_ff;
   logic                byp_ff;
   logic [VALUE_W-1:0]  byp_data_ff;
   logic                rd_ok_ff;
   logic [VALUE_W-1:0]  rd_value;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;

   // Response register
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_recorded_ff, rsp_recorded_in;

   logic                accept;
   logic                slot_ok;
   logic [IDX_W-1:0]    s_idx;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign slot_ok = {1'b0, slot_ff} < NUM_SLOTS_V;
   assign s_idx   = slot_ff[IDX_W-1:0];

   assign rd_value = rd_ok_ff ? (byp_ff ? byp_data_ff : mem_q_ff) : '0;

   assign wr_addr = ADDR_W'(rec_slot_ff) * CAP_ADDR + ADDR_W'(rec_len_ff);
   assign rd_addr = ADDR_W'(play_slot_in) * CAP_ADDR + ADDR_W'(play_pos_in);

   always_comb begin
      logic [LEN_W-1:0] new_len;
      logic [LEN_W-1:0] new_hw;
      new_len      = rec_len_ff + LEN_W'(1);
      new_hw       = (rec_len_ff == rec_hw_ff) ? new_len : rec_hw_ff;
      len_in       = len_ff;
      hw_in        = hw_ff;
      done_in      = done_ff;
      rec_act_in   = rec_act_ff;
      rec_slot_in  = rec_slot_ff;
      rec_last_in  = rec_last_ff;
      rec_len_in   = rec_len_ff;
      rec_hw_in    = rec_hw_ff;
      play_act_in  = play_act_ff;
      play_slot_in = play_slot_ff;
      play_pos_in  = play_pos_ff;
      play_last_in = play_last_ff;
      play_len_in  = play_len_ff;
      play_hw_in   = play_hw_ff;
      wr_en        = 1'b0;
      rsp_value_in = '0;
      if (in_vld_ff) begin
         unique case (act_ff)
            ACT_START_RECORD: begin
               if (slot_ok) begin
                  rec_slot_in    = s_idx;
                  len_in[s_idx]  = '0;
                  done_in[s_idx] = 1'b0;
                  rec_last_in    = now_ff;
                  rec_act_in     = 1'b1;
                  rec_len_in     = '0;
                  rec_hw_in      = hw_ff[s_idx];
                  if (play_slot_ff == s_idx) begin
                     play_len_in = '0;
                  end
               end
            end
            ACT_RECORD_SAMPLE: begin
               if (rec_act_ff && elapsed(now_ff, rec_last_ff, period_ff)) begin
                  rec_last_in = now_ff;
                  if (rec_len_ff < CAP_LEN) begin
                     wr_en                = 1'b1;
                     rec_len_in           = new_len;
                     rec_hw_in            = new_hw;
                     len_in[rec_slot_ff]  = new_len;
                     hw_in[rec_slot_ff]   = new_hw;
                     if (play_slot_ff == rec_slot_ff) begin
                        play_len_in = new_len;
                        play_hw_in  = new_hw;
                     end
                  end
               end
            end
            ACT_STOP_RECORD: begin
               if (rec_act_ff) begin
                  done_in[rec_slot_ff] = (rec_len_ff != '0);
                  rec_act_in           = 1'b0;
               end
            end
            ACT_START_PLAY: begin
               if (slot_ok && done_ff[s_idx] && (len_ff[s_idx] != '0)) begin
                  play_slot_in = s_idx;
                  play_pos_in  = '0;
                  play_last_in = now_ff;
                  play_act_in  = 1'b1;
                  play_len_in  = len_ff[s_idx];
                  play_hw_in   = hw_ff[s_idx];
               end
            end
            ACT_STOP_PLAY: begin
               play_act_in = 1'b0;
            end
            ACT_PLAY_TICK: begin
               if (!play_act_ff) begin
                  rsp_value_in = rd_value;
               end else if (play_len_ff == '0) begin
                  play_act_in = 1'b0;
               end else begin
                  rsp_value_in = rd_value;
                  if (elapsed(now_ff, play_last_ff, period_ff)) begin
                     play_last_in = now_ff;
                     if (LEN_W'(play_pos_ff) + LEN_W'(1) < play_len_ff) begin
                        play_pos_in = play_pos_ff + POS_W'(1);
                     end else begin
                        play_act_in = 1'b0;
                     end
                  end
               end
            end
            ACT_ERASE: begin
               if (slot_ok) begin
                  done_in[s_idx] = 1'b0;
                  len_in[s_idx]  = '0;
                  if (play_slot_ff == s_idx) begin
                     play_len_in = '0;
                     play_act_in = 1'b0;
                  end
                  if (rec_slot_ff == s_idx) begin
                     rec_len_in = '0;
                  end
               end
            end
            ACT_QUERY: begin
            end
            default: begin
            end
         endcase
      end
      rsp_recorded_in = slot_ok && done_in[s_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= accept;
      end
      if (accept) begin
         act_ff  <= action_type'(req_action);
         slot_ff <= req_slot;
         val_ff  <= req_slider_value;
         now_ff  <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '{default: '0};
         hw_ff        <= '{default: '0};
         done_ff      <= '{default: 1'b0};
         rec_act_ff   <= 1'b0;
         rec_slot_ff  <= '0;
         rec_last_ff  <= '0;
         rec_len_ff   <= '0;
         rec_hw_ff    <= '0;
         play_act_ff  <= 1'b0;
         play_slot_ff <= '0;
         play_pos_ff  <= '0;
         play_last_ff <= '0;
         play_len_ff  <= '0;
         play_hw_ff   <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         len_ff       <= len_in;
         hw_ff        <= hw_in;
         done_ff      <= done_in;
         rec_act_ff   <= rec_act_in;
         rec_slot_ff  <= rec_slot_in;
         rec_last_ff  <= rec_last_in;
         rec_len_ff   <= rec_len_in;
         rec_hw_ff    <= rec_hw_in;
         play_act_ff  <= play_act_in;
         play_slot_ff <= play_slot_in;
         play_pos_ff  <= play_pos_in;
         play_last_ff <= play_last_in;
         play_len_ff  <= play_len_in;
         play_hw_ff   <= play_hw_in;
         // Entries at or above the high-water mark were never written since reset.
         rd_ok_ff     <= LEN_W'(play_pos_in) < play_hw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= val_ff;
      end
   end

   // The store returns old data on a same-address write, so the new word is carried aside.
   always_ff @(posedge clock) begin
      mem_q_ff    <= sample_mem[rd_addr];
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_vld_ff;
      end
      rsp_value_ff    <= rsp_value_in;
      rsp_recorded_ff <= rsp_recorded_in;
   end

   logic                rsp_playing_ff;
   logic [IDX_W-1:0]    rsp_slot_ff;
   logic                rsp_recording_ff;

   always_ff @(posedge clock) begin
      rsp_playing_ff   <= play_act_in;
      rsp_slot_ff      <= play_slot_in;
      rsp_recording_ff <= rec_act_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_play_value    = rsp_value_ff;
   assign rsp_playing       = rsp_playing_ff;
   assign rsp_playing_slot  = SLOT_W'(rsp_slot_ff);
   assign rsp_slot_recorded = rsp_recorded_ff;
   assign rsp_recording     = rsp_recording_ff;

   a_rec_len_copy: assert property (@(posedge clock) disable iff (reset)
      rec_act_ff |-> (rec_len_ff == len_ff[rec_slot_ff]))
      else $error("recording length copy disagrees with slot length");

   a_play_len_copy: assert property (@(posedge clock) disable iff (reset)
      (play_len_ff == len_ff[play_slot_ff]) && (play_hw_ff == hw_ff[play_slot_ff]))
      else $error("playback slot copies disagree with slot bookkeeping");

   a_rec_hw: assert property (@(posedge clock) disable iff (reset)
      rec_act_ff |-> (rec_hw_ff >= rec_len_ff) && (rec_len_ff <= CAP_LEN))
      else $error("recording length exceeds high-water mark or capacity");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff |=> rsp_valid_ff)
      else $error("word in input register produced no response");

   a_no_stray_rsp: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |=> !rsp_valid_ff)
      else $error("response without a word");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the slot record and playback engine.
module tb_top
   import srpe_pkg::*;
();

   localparam int NUM_SLOTS      = 10;
   localparam int SLOT_CAP       = 1024;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 6;
   localparam int PHASE_QUOTA    = 105;

   typedef struct packed {
      logic [VALUE_W-1:0] play_value;
      logic               playing;
      logic [SLOT_W-1:0]  playing_slot;
      logic               slot_recorded;
      logic               recording;
   } engine_reply_type;

   class slot_engine_scoreboard;
      bit [VALUE_W-1:0]  samples [NUM_SLOTS*SLOT_CAP];
      bit [10:0]         fill_count [NUM_SLOTS];
      bit                take_done [NUM_SLOTS];
      bit                rec_on;
      bit [SLOT_W-1:0]   rec_slot;
      bit [TIME_W-1:0]   rec_stamp;
      bit                play_on;
      bit [SLOT_W-1:0]   play_slot_q;
      bit [9:0]          play_pos;
      bit [TIME_W-1:0]   play_stamp;
      bit [PERIOD_W-1:0] period;
      engine_reply_type  replies_due[$];
      int                fail_count;

      function new();
         period = PERIOD_RESET;
      endfunction

      function void set_period(logic [PERIOD_W-1:0] value);
         period = value;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function bit elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last);
         logic [TIME_W-1:0] gap;
         gap = now - last;
         return gap >= {16'd0, period};
      endfunction

      function logic [VALUE_W-1:0] stored(logic [SLOT_W-1:0] s, logic [9:0] pos);
         if (s >= NUM_SLOTS) return '0;
         return samples[s*SLOT_CAP + pos];
      endfunction

      function void take_command(action_type act, logic [SLOT_W-1:0] slot,
                                 logic [VALUE_W-1:0] value, logic [TIME_W-1:0] now);
         bit               in_range;
         int               fill;
         engine_reply_type reply;
         in_range = slot < NUM_SLOTS;
         reply    = '0;
         case (act)
            ACT_START_RECORD: if (in_range) begin
               rec_slot         = slot;
               fill_count[slot] = '0;
               take_done[slot]  = 1'b0;
               rec_stamp        = now;
               rec_on           = 1'b1;
            end
            ACT_RECORD_SAMPLE: begin
               if (rec_on && rec_slot < NUM_SLOTS && elapsed(now, rec_stamp)) begin
                  // A full slot still restarts the sample period.
                  rec_stamp = now;
                  fill      = int'(fill_count[rec_slot]);
                  if (fill < SLOT_CAP) begin
                     samples[rec_slot*SLOT_CAP + fill] = value;
                     fill_count[rec_slot]             = 11'(fill + 1);
                  end
               end
            end
            ACT_STOP_RECORD: if (rec_on && rec_slot < NUM_SLOTS) begin
               take_done[rec_slot] = fill_count[rec_slot] != 0;
               rec_on              = 1'b0;
            end
            ACT_START_PLAY: begin
               if (in_range && take_done[slot] && fill_count[slot] != 0) begin
                  play_slot_q = slot;
                  play_pos    = '0;
                  play_stamp  = now;
                  play_on     = 1'b1;
               end
            end
            ACT_STOP_PLAY: play_on = 1'b0;
            ACT_PLAY_TICK: begin
               if (!play_on) begin
                  reply.play_value = stored(play_slot_q, play_pos);
               end else if (play_slot_q >= NUM_SLOTS || fill_count[play_slot_q] == 0) begin
                  play_on = 1'b0;
               end else begin
                  reply.play_value = stored(play_slot_q, play_pos);
                  if (elapsed(now, play_stamp)) begin
                     play_stamp = now;
                     if (play_pos + 1 < fill_count[play_slot_q]) play_pos = 10'(play_pos + 1);
                     else play_on = 1'b0;
                  end
               end
            end
            ACT_ERASE: if (in_range) begin
               take_done[slot]  = 1'b0;
               fill_count[slot] = '0;
               if (play_on && play_slot_q == slot) play_on = 1'b0;
            end
            default: ;
         endcase
         reply.playing       = play_on;
         reply.playing_slot  = play_slot_q;
         reply.slot_recorded = in_range ? take_done[slot] : 1'b0;
         reply.recording     = rec_on;
         replies_due.push_back(reply);
      endfunction

      function void check_reply(engine_reply_type got);
         engine_reply_type want;
         if (replies_due.size() == 0) begin
            $error("response word with no command outstanding");
            fail_count++;
            return;
         end
         want = replies_due.pop_front();
         if (got.play_value !== want.play_value) begin
            $error("play_value: expected %0d, got %0d", want.play_value, got.play_value);
            fail_count++;
         end
         if (got.playing !== want.playing) begin
            $error("playing: expected %0d, got %0d", want.playing, got.playing);
            fail_count++;
         end
         if (got.playing_slot !== want.playing_slot) begin
            $error("playing_slot: expected %0d, got %0d", want.playing_slot, got.playing_slot);
            fail_count++;
         end
         if (got.slot_recorded !== want.slot_recorded) begin
            $error("slot_recorded: expected %0d, got %0d", want.slot_recorded,
                   got.slot_recorded);
            fail_count++;
         end
         if (got.recording !== want.recording) begin
            $error("recording: expected %0d, got %0d", want.recording, got.recording);
            fail_count++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [VALUE_W-1:0]  req_slider_value = '0;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic                csr_wr_en = 1'b0;
   logic [PERIOD_W-1:0] csr_wr_data = '0;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_play_value;
   logic                rsp_playing;
   logic [SLOT_W-1:0]   rsp_playing_slot;
   logic                rsp_slot_recorded;
   logic                rsp_recording;

   slot_engine_scoreboard scoreboard = new();
   int                    quiet_cycles = 0;
   int                    idle_pct = 0;
   int                    sent_count = 0;
   logic [TIME_W-1:0]     wall_ms = '0;
   int unsigned           step_period = 32'(PERIOD_RESET);

   slot_record_playback_engine_unit #(
      .NUM_SLOTS     (NUM_SLOTS),
      .SLOT_CAPACITY (SLOT_CAP)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_slider_value  (req_slider_value),
      .req_now_ms        (req_now_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_play_value    (rsp_play_value),
      .rsp_playing       (rsp_playing),
      .rsp_playing_slot  (rsp_playing_slot),
      .rsp_slot_recorded (rsp_slot_recorded),
      .rsp_recording     (rsp_recording)
   );

   always #4 clock = ~clock;

   // The response is checked before the new command is noted, so a response can never be
   // matched against the word taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            scoreboard.check_reply({rsp_play_value, rsp_playing, rsp_playing_slot,
                                    rsp_slot_recorded, rsp_recording});
         if (start && !busy)
            scoreboard.take_command(action_type'(req_action), req_slot, req_slider_value,
                                    req_now_ms);
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("slot_record_playback_engine_unit verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (scoreboard.pending() != 0) @(negedge clock);
   endtask

   task automatic issue(action_type act, logic [SLOT_W-1:0] slot,
                        logic [VALUE_W-1:0] value, logic [TIME_W-1:0] now);
      if ($urandom_range(99) == 0) drain();
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_action       <= act;
      req_slot         <= slot;
      req_slider_value <= value;
      req_now_ms       <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   task automatic write_period(logic [PERIOD_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      scoreboard.set_period(value);
      step_period = 32'(value);
   endtask

   // Steps the millisecond clock mostly around one period, with jumps that wrap.
   function automatic logic [TIME_W-1:0] tick_clock();
      case ($urandom_range(9))
         0:       ;
         1, 2:    wall_ms += $urandom_range(step_period);
         3, 4, 5: wall_ms += step_period + $urandom_range(3);
         6:       wall_ms += (step_period == 0) ? 0 : step_period - 1;
         7, 8:    wall_ms += $urandom_range(3*step_period + 5);
         default: wall_ms = $urandom();
      endcase
      return wall_ms;
   endfunction

   task automatic send_noise();
      issue(action_type'($urandom_range(7)), SLOT_W'($urandom_range(15)),
            VALUE_W'($urandom_range(255)), tick_clock());
   endtask

   // Records a handful of values into one slot, then plays the slot back, with stray
   // commands mixed in.
   task automatic record_and_replay(int takes);
      logic [SLOT_W-1:0] slot;
      slot = ($urandom_range(6) == 0) ? SLOT_W'($urandom_range(15, NUM_SLOTS))
                                      : SLOT_W'($urandom_range(NUM_SLOTS-1));
      issue(ACT_START_RECORD, slot, VALUE_W'($urandom_range(255)), tick_clock());
      repeat (takes) begin
         if ($urandom_range(9) == 0) send_noise();
         else issue(ACT_RECORD_SAMPLE, SLOT_W'($urandom_range(15)),
                    VALUE_W'($urandom_range(255)), tick_clock());
      end
      issue(ACT_STOP_RECORD, SLOT_W'($urandom_range(15)), VALUE_W'($urandom_range(255)),
            tick_clock());
      issue(ACT_START_PLAY, slot, VALUE_W'($urandom_range(255)), tick_clock());
      repeat (takes + 2) begin
         if ($urandom_range(9) == 0) send_noise();
         else issue(ACT_PLAY_TICK, SLOT_W'($urandom_range(15)),
                    VALUE_W'($urandom_range(255)), tick_clock());
      end
   endtask

   initial begin
      int unsigned phase_period [PHASES] = '{0, 1, 65535, 7, 300, 50};
      int          phase_idle   [PHASES] = '{0, 55, 21, 55, 0, 21};
      int          phase_end;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset period of 50 ms.
      issue(ACT_QUERY, 4'd0, 8'd0, 32'd1000);
      issue(ACT_PLAY_TICK, 4'd0, 8'd0, 32'd1000);
      issue(ACT_RECORD_SAMPLE, 4'd2, 8'hFF, 32'd1000);
      issue(ACT_STOP_RECORD, 4'd2, 8'd0, 32'd1000);
      issue(ACT_START_RECORD, 4'd15, 8'd0, 32'd1000);
      issue(ACT_START_PLAY, 4'd0, 8'd0, 32'd1000);
      issue(ACT_START_RECORD, 4'd9, 8'd0, 32'd1000);
      issue(ACT_RECORD_SAMPLE, 4'd0, 8'hFF, 32'd1050);
      issue(ACT_RECORD_SAMPLE, 4'd0, 8'h00, 32'd1099);
      // Switching slots mid-recording leaves slot 9 filled but unmarked.
      issue(ACT_START_RECORD, 4'd0, 8'd0, 32'd1100);
      issue(ACT_RECORD_SAMPLE, 4'd0, 8'h5A, 32'd1150);
      issue(ACT_STOP_RECORD, 4'd0, 8'd0, 32'd1160);
      issue(ACT_QUERY, 4'd9, 8'd0, 32'd1170);
      issue(ACT_START_PLAY, 4'd0, 8'd0, 32'd1200);
      issue(ACT_START_RECORD, 4'd0, 8'd0, 32'd1210);
      issue(ACT_PLAY_TICK, 4'd0, 8'd0, 32'd1300);
      issue(ACT_STOP_RECORD, 4'd0, 8'd0, 32'd1310);
      issue(ACT_START_RECORD, 4'd3, 8'd0, 32'hFFFF_FFF0);
      issue(ACT_RECORD_SAMPLE, 4'd0, 8'h80, 32'h0000_0030);
      issue(ACT_STOP_RECORD, 4'd0, 8'd0, 32'h0000_0080);
      issue(ACT_START_PLAY, 4'd3, 8'd0, 32'h0000_0100);
      issue(ACT_PLAY_TICK, 4'd0, 8'd0, 32'h0000_0110);
      issue(ACT_PLAY_TICK, 4'd0, 8'd0, 32'h0000_0140);
      issue(ACT_PLAY_TICK, 4'd0, 8'd0, 32'h0000_0150);
      issue(ACT_START_PLAY, 4'd3, 8'd0, 32'h0000_0160);
      issue(ACT_ERASE, 4'd3, 8'd0, 32'h0000_0170);
      issue(ACT_STOP_PLAY, 4'd0, 8'd0, 32'h0000_0180);
      issue(ACT_QUERY, 4'd12, 8'd0, 32'h0000_0190);
      wall_ms = 32'h0000_0200;

      for (int p = 0; p < PHASES; p++) begin
         write_period(PERIOD_W'(phase_period[p]));
         idle_pct = phase_idle[p];
         if (p == 0) begin
            // With no period every sample is taken, so one slot runs past full.
            issue(ACT_START_RECORD, 4'd5, 8'd0, tick_clock());
            repeat (SLOT_CAP + 6)
               issue(ACT_RECORD_SAMPLE, SLOT_W'($urandom_range(15)),
                     VALUE_W'($urandom_range(255)), tick_clock());
            issue(ACT_STOP_RECORD, 4'd0, 8'd0, tick_clock());
            issue(ACT_START_PLAY, 4'd5, 8'd0, tick_clock());
            repeat (40) issue(ACT_PLAY_TICK, 4'd0, 8'd0, tick_clock());
            issue(ACT_STOP_PLAY, 4'd0, 8'd0, tick_clock());
         end
         phase_end = sent_count + PHASE_QUOTA;
         while (sent_count < phase_end) begin
            if ($urandom_range(3) == 0) repeat (5) send_noise();
            else record_and_replay($urandom_range(12, 1));
         end
      end

      drain();
      repeat (4) @(negedge clock);
      if (scoreboard.fail_count == 0 && scoreboard.pending() == 0)
         $display("slot_record_playback_engine_unit verification clean");
      else
         $display("slot_record_playback_engine_unit verification failed");
      $finish;
   end

endmodule

FILE: slot_record_playback_engine_unit.f
design/srpe_pkg.sv
design/slot_record_playback_engine_unit.sv
tb/tb_top.sv
